FILE: sv/mr90_pkg.sv
// Shared constants, command/status types and a helper for the matrix rotation core.
package mr90_pkg;

   localparam int MAX_SIDE = 8;
   localparam int SIDE_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int ADDR_W   = 2 * SIDE_W;
   localparam int DEPTH    = 1 << ADDR_W;
   localparam int DATA_W   = 32;
   localparam int SIZE_W   = 4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIDE);

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              rd_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic rd_pending;
   } sts_type;

   // Highest row/column index for a written size; zero acts as one, large values clamp.
   function automatic logic [SIDE_W-1:0] side_last(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      n = size;
      if (n == '0) begin
         n = SIZE_W'(1);
      end
      if (n > SIZE_W'(MAX_SIDE)) begin
         n = SIZE_W'(MAX_SIDE);
      end
      return SIDE_W'(n - SIZE_W'(1));
   endfunction

endpackage

FILE: sv/matrix_rotate_90_core.sv
// Top level of the 90-degree clockwise matrix rotation core.
// Load: one request per cycle, N*N requests fill the buffer in row-major order.
// Emit: N*N responses, each a buffer read, then the response register; one read in flight at a time.
// The first response of a matrix passes the state register, the buffer read and the response register.
// Load and emit do not overlap: no request is accepted while a matrix is emitted.
// Synchronous reset: size returns to the maximum side, load position to zero, buffer not cleared.
module matrix_rotate_90_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mr90_pkg::DATA_W-1:0]    req_element_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mr90_pkg::DATA_W-1:0]    rsp_rotated_value,
   output logic                           rsp_last_of_matrix,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mr90_pkg::SIZE_W-1:0]    csr_matrix_size
);

   mr90_pkg::cmd_type cmd;
   mr90_pkg::sts_type sts;

   mr90_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_matrix_size (csr_matrix_size),
      .sts             (sts),
      .cmd             (cmd)
   );

   mr90_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rotated_value  (rsp_rotated_value),
      .rsp_last_of_matrix (rsp_last_of_matrix)
   );

   a_one_read_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !sts.rd_pending)
      else $error("read issued while another read is pending");

   a_landing_slot_free: assert property (@(posedge clock) disable iff (reset)
      sts.rd_pending |-> !rsp_valid)
      else $error("read data lands on an occupied response register");

   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !cmd.rd_en)
      else $error("buffer written and read in the same cycle");

   a_read_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> sts.out_free)
      else $error("read issued without room for its response");

endmodule

FILE: sv/mr90_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mr90_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mr90_dp.sv
// Datapath: element buffer, read tracking and response register.
module mr90_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  mr90_pkg::cmd_type              cmd,
   output mr90_pkg::sts_type              sts,
   input  logic [mr90_pkg::DATA_W-1:0]    req_element_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mr90_pkg::DATA_W-1:0]    rsp_rotated_value,
   output logic                           rsp_last_of_matrix
);

   logic [mr90_pkg::DATA_W-1:0] rd_data;
   logic                        rd_pending_ff, rd_pending_in;
   logic                        last_pending_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mr90_pkg::DATA_W-1:0] rsp_value_ff;
   logic                        rsp_last_ff;

   mr90_ram #(
      .WIDTH (mr90_pkg::DATA_W),
      .DEPTH (mr90_pkg::DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (req_element_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rd_pending_in = cmd.rd_en;
      rsp_valid_in  = rsp_valid_ff;
      if (rd_pending_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (cmd.rd_en) begin
         last_pending_ff <= cmd.rd_last;
      end
      if (rd_pending_ff) begin
         rsp_value_ff <= rd_data;
         rsp_last_ff  <= last_pending_ff;
      end
   end

   assign sts.out_free       = !rsp_valid_ff || rsp_ready;
   assign sts.rd_pending     = rd_pending_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rotated_value  = rsp_value_ff;
   assign rsp_last_of_matrix = rsp_last_ff;

endmodule

FILE: sv/mr90_ctrl.sv
// Controller: size register, load counters and rotated read-out sequencing.
module mr90_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mr90_pkg::SIZE_W-1:0]    csr_matrix_size,
   input  mr90_pkg::sts_type              sts,
   output mr90_pkg::cmd_type              cmd
);

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [mr90_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [mr90_pkg::SIDE_W-1:0] row_ff, row_in;
   logic [mr90_pkg::SIDE_W-1:0] col_ff, col_in;
   logic [mr90_pkg::SIDE_W-1:0] last_idx;
   logic                        req_fire;
   logic                        rd_fire;
   logic                        emit_last;

   assign last_idx  = mr90_pkg::side_last(size_ff);
   assign req_ready = (state_ff == ST_LOAD);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rd_fire   = (state_ff == ST_EMIT) && !sts.rd_pending && sts.out_free;
   assign emit_last = (row_ff == last_idx) && (col_ff == last_idx);

   // In load, row/col walk the input; in emit, row is output row i and col is output column j.
   always_comb begin
      cmd.wr_en   = req_fire;
      cmd.wr_addr = {row_ff, col_ff};
      cmd.rd_en   = rd_fire;
      cmd.rd_addr = {mr90_pkg::SIDE_W'(last_idx - col_ff), row_ff};
      cmd.rd_last = emit_last;
   end

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (csr_valid) begin
         size_in  = csr_matrix_size;
         row_in   = '0;
         col_in   = '0;
         state_in = ST_LOAD;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (col_ff == last_idx) begin
                     col_in = '0;
                     if (row_ff == last_idx) begin
                        row_in   = '0;
                        state_in = ST_EMIT;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
            ST_EMIT: begin
               if (rd_fire) begin
                  if (col_ff == last_idx) begin
                     col_in = '0;
                     if (row_ff == last_idx) begin
                        row_in   = '0;
                        state_in = ST_LOAD;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_in = ST_LOAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         size_ff  <= mr90_pkg::SIZE_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

FILE: tb/sv/matrix_rotate_90_core_tb.sv
// Self-checking testbench for matrix_rotate_90_core with a built-in rotation predictor.
`timescale 1ns / 100ps

module matrix_rotate_90_core_tb;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RAND_ITEMS    = 80;
   localparam int N_DIRECTED    = 26;
   localparam int BUF_WORDS     = mr90_pkg::DEPTH;

   typedef enum logic {ROW_SIZE, ROW_ELEM} row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic [mr90_pkg::DATA_W-1:0] data;
      bit                          typed;
      logic [mr90_pkg::DATA_W-1:0] exp_value;
      bit                          exp_last;
   } dir_row_type;

   typedef struct {
      logic signed [mr90_pkg::DATA_W-1:0] value;
      logic                               last;
   } rot_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [mr90_pkg::DATA_W-1:0]   req_element_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [mr90_pkg::DATA_W-1:0]   rsp_rotated_value;
   logic                          rsp_last_of_matrix;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [mr90_pkg::SIZE_W-1:0]   csr_matrix_size = '0;

   logic [mr90_pkg::DATA_W-1:0]   shadow_buf [BUF_WORDS];
   int unsigned                   fill_cnt = 0;
   logic [mr90_pkg::SIZE_W-1:0]   size_reg = mr90_pkg::SIZE_RESET;
   rot_beat_type                  fresh_beats [$];
   rot_beat_type                  pending_beats [$];
   int                            mismatch_count = 0;
   int                            cycle_count = 0;
   bit                            tx_burst = 1'b0;
   bit                            hold_rsp = 1'b0;

   dir_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_ELEM, 32'h1111_1111, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h2222_2222, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h3333_3333, 1'b0, 32'h0, 1'b0},
      '{ROW_SIZE, 32'd1,         1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{ROW_ELEM, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
      '{ROW_ELEM, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_ELEM, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_SIZE, 32'd0,         1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 1'b1},
      '{ROW_SIZE, 32'd2,         1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h0000_0004, 1'b0, 32'h0, 1'b0},
      '{ROW_SIZE, 32'd3,         1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h8000_0001, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h7FFF_FFFE, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h5555_5555, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h0F0F_0F0F, 1'b0, 32'h0, 1'b0},
      '{ROW_SIZE, 32'd2,         1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{ROW_ELEM, 32'h0000_0000, 1'b0, 32'h0, 1'b0}
   };

   matrix_rotate_90_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rotated_value  (rsp_rotated_value),
      .rsp_last_of_matrix (rsp_last_of_matrix),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_matrix_size    (csr_matrix_size)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int unsigned side_of(input logic [mr90_pkg::SIZE_W-1:0] sz);
      int unsigned n;
      n = sz;
      if (n < 1) n = 1;
      if (n > mr90_pkg::MAX_SIDE) n = mr90_pkg::MAX_SIDE;
      return n;
   endfunction

   function automatic void rotate_load(input logic [mr90_pkg::DATA_W-1:0] v);
      int unsigned  n, total, src, k;
      rot_beat_type beat;
      n = side_of(size_reg);
      total = n * n;
      if (fill_cnt >= total) fill_cnt = 0;
      shadow_buf[fill_cnt % BUF_WORDS] = v;
      fill_cnt = (fill_cnt + 1) & 32'h7F;
      if (fill_cnt < total) return;
      k = 0;
      for (int unsigned i = 0; i < n; i++) begin
         for (int unsigned j = 0; j < n; j++) begin
            src = ((n - 1 - j) * n + i) % BUF_WORDS;
            beat.value = shadow_buf[src];
            beat.last = (k == total - 1);
            fresh_beats.push_back(beat);
            k++;
         end
      end
      fill_cnt = 0;
   endfunction

   function automatic logic [mr90_pkg::DATA_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_element(input logic [mr90_pkg::DATA_W-1:0] v, input bit typed,
                               input logic [mr90_pkg::DATA_W-1:0] tv, input bit tl);
      int           gap;
      rot_beat_type beat;
      gap = tx_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= v;
      do @(posedge clock); while (!req_ready);
      fresh_beats.delete();
      rotate_load(v);
      if (typed) begin
         beat.value = tv;
         beat.last = tl;
         pending_beats.push_back(beat);
      end else begin
         foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
      end
   endtask

   task automatic wait_matrix_out();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
   endtask

   task automatic write_size(input logic [mr90_pkg::SIZE_W-1:0] sz);
      wait_matrix_out();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_matrix_size <= sz;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = sz;
      fill_cnt = 0;
   endtask

   initial begin : rsp_side
      int           stall;
      int           since_redraw;
      bit           rx_burst;
      rot_beat_type want;
      since_redraw = 0;
      rx_burst = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            stall = rx_burst ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (pending_beats.size() == 0) begin
            $error("unexpected response: rotated_value %h last_of_matrix %b",
                   rsp_rotated_value, rsp_last_of_matrix);
            mismatch_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_rotated_value !== want.value) begin
               $error("rotated_value: expected %h, got %h", want.value, rsp_rotated_value);
               mismatch_count++;
            end
            if (rsp_last_of_matrix !== want.last) begin
               $error("last_of_matrix: expected %b, got %b", want.last, rsp_last_of_matrix);
               mismatch_count++;
            end
         end
         since_redraw++;
         if (since_redraw == 16) begin
            since_redraw = 0;
            rx_burst = ($urandom_range(0, 2) == 0);
         end
      end
   end

   initial begin : stimulus
      int                          rand_items;
      int                          p;
      int                          nmat;
      int                          total;
      int                          tail;
      logic [mr90_pkg::SIZE_W-1:0] sz;
      rand_items = 0;
      p = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SIZE) begin
            write_size(directed_rows[r].data[mr90_pkg::SIZE_W-1:0]);
         end else begin
            push_element(directed_rows[r].data, directed_rows[r].typed,
                         directed_rows[r].exp_value, directed_rows[r].exp_last);
         end
      end

      while (p < 3 || rand_items < RAND_ITEMS) begin
         if (p == 0) begin
            sz = 4'd15;
         end else if (p == 1) begin
            sz = 4'd2;
         end else if (p == 2) begin
            sz = 4'd3;
         end else if ($urandom_range(0, 3) == 0) begin
            sz = 4'($urandom_range(0, 15));
         end else begin
            sz = 4'($urandom_range(1, 4));
         end
         write_size(sz);
         total = side_of(sz) * side_of(sz);
         if (p == 1) begin
            nmat = 2;
         end else if (p == 2) begin
            nmat = 2;
         end else begin
            nmat = (total >= 16) ? 1 : $urandom_range(1, 3);
         end
         tx_burst = ($urandom_range(0, 3) == 0);
         if (p == 1) hold_rsp = 1'b1;
         for (int m = 0; m < nmat; m++) begin
            for (int k = 0; k < total; k++) begin
               push_element(rand_word(), 1'b0, '0, 1'b0);
               rand_items++;
            end
            if (p == 2 && m == 0) wait_matrix_out();
         end
         // drop a partial matrix on the next size write
         if (total > 1 && $urandom_range(0, 2) == 0) begin
            tail = $urandom_range(1, (total - 1 > 3) ? 3 : total - 1);
            repeat (tail) begin
               push_element(rand_word(), 1'b0, '0, 1'b0);
               rand_items++;
            end
         end
         p++;
      end

      wait_matrix_out();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
